FILE: src/sau_pkg.sv
package sau_pkg;

  // Word and field widths
  localparam int XLEN    = 32;
  localparam int REQ_W   = 3;
  localparam int ST_W    = 2;
  localparam int DEPTH_W = 7;
  localparam int STEP_W  = $clog2(XLEN);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SUB  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MUL  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DIV  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CMP  = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // latch item, start read of second entry
    logic exec;      // commit a push, pop, add, sub or compare, or an error
    logic mul_go;    // register the product
    logic div_go;    // load the divider
    logic div_step;  // one quotient bit
    logic fin;       // commit a multiply or divide result
  } sau_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic long_mul;  // latched request is a multiply with operands present
    logic long_div;  // latched request is a divide with a non-zero divisor
    logic div_last;  // final quotient bit this cycle
  } sau_sts_t;

endpackage

FILE: src/sau_ram.sv
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one word, read one word into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/sau_ctrl.sv
module sau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sau_pkg::sau_sts_t sts,
  output sau_pkg::sau_cmd_t cmd
);

  import sau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OPER = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one request at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_OPER;
        end
      end
      S_OPER: begin
        if (sts.long_mul) begin
          cmd.mul_go = 1'b1;
          state_nxt  = S_FIN;
        end else if (sts.long_div) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIV;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/sau_dp.sv
module sau_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sau_pkg::sau_cmd_t                    cmd,
  output sau_pkg::sau_sts_t                    sts,
  input  logic [sau_pkg::REQ_W-1:0]            req_type,
  input  logic signed [sau_pkg::XLEN-1:0]      push_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sau_pkg::XLEN-1:0]      result_value,
  output logic [sau_pkg::ST_W-1:0]             status,
  output logic [sau_pkg::DEPTH_W-1:0]          depth_now
);

  import sau_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int DW = (CW > DEPTH_W) ? CW : DEPTH_W;

  // Latched item and stack state; the top entry lives in tos_r
  logic [REQ_W-1:0]  req_r;
  logic [XLEN-1:0]   pv_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [XLEN-1:0]   tos_r, tos_nxt;

  // Multiply result and divider
  logic [XLEN-1:0]   quo_r;
  logic [XLEN-1:0]   rem_r;
  logic [XLEN-1:0]   dsr_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;

  // Output register
  logic              out_valid_r;
  logic [XLEN-1:0]   out_res_r;
  logic [ST_W-1:0]   out_st_r;
  logic [DEPTH_W-1:0] out_depth_r;

  logic [XLEN-1:0]   rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  logic              full, cnt_zero, lt2;
  logic [ST_W-1:0]   st_op;
  logic [XLEN-1:0]   res_op, tos_op;
  logic [CW-1:0]     cnt_op;
  logic [XLEN-1:0]   prod_lo, fin_val, abs_a, abs_b;
  logic [XLEN:0]     rem_sh, trial;
  logic [DW-1:0]     depth_wide;
  logic              load_out;

  // Entries below the top sit in memory at index count-2 and lower
  sau_ram #(.WIDTH(XLEN), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tos_r),
    .rd_en   (cmd.take),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_addr  = count_r[AW-1:0] - AW'(2);
  assign wr_addr  = count_r[AW-1:0] - AW'(1);
  assign full     = (count_r == CW'(DEPTH));
  assign cnt_zero = (count_r == '0);
  assign lt2      = (count_r < CW'(2));

  // Spill the old top on a successful push
  assign wr_en = cmd.exec && (req_r == REQ_PUSH) && !full && !cnt_zero;

  // Decode the latched request against the top two entries
  always_comb begin
    st_op  = ST_OK;
    res_op = '0;
    tos_op = tos_r;
    cnt_op = count_r;
    case (req_r)
      REQ_PUSH: begin
        if (full) begin
          st_op = ST_OVER;
        end else begin
          tos_op = pv_r;
          cnt_op = count_r + CW'(1);
        end
      end
      REQ_POP: begin
        if (cnt_zero) begin
          st_op = ST_UNDER;
        end else begin
          res_op = tos_r;
          tos_op = rd_data;
          cnt_op = count_r - CW'(1);
        end
      end
      REQ_ADD: begin
        if (lt2) begin
          st_op = ST_UNDER;
        end else begin
          tos_op = rd_data + tos_r;
          cnt_op = count_r - CW'(1);
        end
      end
      REQ_SUB: begin
        if (lt2) begin
          st_op = ST_UNDER;
        end else begin
          tos_op = rd_data - tos_r;
          cnt_op = count_r - CW'(1);
        end
      end
      REQ_MUL: begin
        if (lt2) begin
          st_op = ST_UNDER;
        end
      end
      REQ_DIV: begin
        if (lt2) begin
          st_op = ST_UNDER;
        end else if (tos_r == '0) begin
          st_op = ST_DIVZ;
        end
      end
      REQ_CMP: begin
        if (lt2) begin
          st_op = ST_UNDER;
        end else begin
          res_op = tos_r - rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.long_mul = (req_r == REQ_MUL) && !lt2;
  assign sts.long_div = (req_r == REQ_DIV) && !lt2 && (tos_r != '0);
  assign sts.div_last = (step_r == STEP_W'(XLEN - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // Low word of the product, magnitudes for the divider
  assign prod_lo = rd_data * tos_r;
  assign abs_b   = rd_data[XLEN-1] ? (XLEN'(0) - rd_data) : rd_data;
  assign abs_a   = tos_r[XLEN-1] ? (XLEN'(0) - tos_r) : tos_r;
  assign fin_val = neg_r ? (XLEN'(0) - quo_r) : quo_r;

  // Restoring division, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[XLEN-1]};
  assign trial  = rem_sh - {1'b0, dsr_r};

  // Next top and count
  always_comb begin
    tos_nxt   = tos_r;
    count_nxt = count_r;
    if (cmd.exec) begin
      tos_nxt   = tos_op;
      count_nxt = cnt_op;
    end else if (cmd.fin) begin
      tos_nxt   = fin_val;
      count_nxt = count_r - CW'(1);
    end
  end

  assign load_out   = cmd.exec || cmd.fin;
  assign depth_wide = DW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (cmd.take) begin
      req_r <= req_type;
      pv_r  <= push_value;
    end
    if (cmd.mul_go) begin
      quo_r <= prod_lo;
      neg_r <= 1'b0;
    end else if (cmd.div_go) begin
      quo_r  <= abs_b;
      dsr_r  <= abs_a;
      rem_r  <= '0;
      neg_r  <= rd_data[XLEN-1] ^ tos_r[XLEN-1];
      step_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[XLEN]) begin
        rem_r <= trial[XLEN-1:0];
        quo_r <= {quo_r[XLEN-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[XLEN-1:0];
        quo_r <= {quo_r[XLEN-2:0], 1'b0};
      end
      step_r <= step_r + STEP_W'(1);
    end
    if (load_out) begin
      out_res_r   <= cmd.exec ? res_op : '0;
      out_st_r    <= cmd.exec ? st_op : ST_OK;
      out_depth_r <= depth_wide[DEPTH_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign result_value = out_res_r;
  assign status       = out_st_r;
  assign depth_now    = out_depth_r;

endmodule

FILE: src/stack_arithmetic_unit_core.sv
// Channel  Dir  Handshake             tdata                          tuser
// in_      in   in_tvalid/in_tready   [31:0] push_value              [2:0] req_type
// out_     out  out_tvalid/out_tready [31:0] result_value,           [1:0] status
//                                     [38:32] depth_now, [39] zero
//
// One item at a time. Push, pop, add, sub, compare and errors read the second
// entry from the stack memory, then commit. Multiply registers the product;
// divide makes one quotient bit a cycle.
// Reset empties the stack; memory contents are not cleared.
// A result waiting in the output register stalls only the commit of the next item.
module stack_arithmetic_unit_core #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] result_value, [38:32] depth_now, [39] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import sau_pkg::*;

  sau_cmd_t           cmd;
  sau_sts_t           sts;
  logic [XLEN-1:0]    result_value;
  logic [DEPTH_W-1:0] depth_now;

  sau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sau_dp #(.DEPTH(DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_tuser),
    .push_value   (in_tdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .result_value (result_value),
    .status       (out_tuser),
    .depth_now    (depth_now)
  );

  assign out_tdata = {1'b0, depth_now, result_value};

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.fin) |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending item");

  // An accepted item is followed by a busy cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in flight");

  // Each item commits through one path only
  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.fin))
    else $error("two commits in one cycle");

  // A commit always makes a result visible next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.fin) |=> out_tvalid)
    else $error("commit without a result");

endmodule
